[sv/tkst_pkg.sv]
`default_nettype none
package tkst_pkg;

    // Fixed field widths
    localparam int CFG_BITS        = 7;
    localparam int SUM_BITS        = 38;
    localparam int NUM_ENTRIES_DEF = 64;
    localparam int VALUE_BITS_DEF  = 32;

    // Register indexes on the configuration port
    localparam logic REG_ENTRIES_IN_USE = 1'b0;
    localparam logic REG_TOP_COUNT      = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_REMOVE,
        S_INSERT,
        S_SCAN,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic find;
        logic remove;
        logic insert;
        logic accum;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last;
        logic err;
    } t_status;

endpackage
`default_nettype wire

[sv/tkst_datapath.sv]
`default_nettype none
module tkst_datapath #(
    parameter int NUM_ENTRIES = 64,
    parameter int VALUE_BITS  = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_wen,
    input  wire                             i_cfg_index,
    input  wire [tkst_pkg::CFG_BITS-1:0]    i_cfg_data,
    input  wire [$clog2(NUM_ENTRIES)-1:0]   i_entry_index,
    input  wire [VALUE_BITS-1:0]            i_new_value,
    input  tkst_pkg::t_cmd                  i_cmd,
    output tkst_pkg::t_status               o_status,
    output logic [tkst_pkg::SUM_BITS-1:0]   o_top_sum,
    output logic                            o_index_error
);
    import tkst_pkg::*;

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int NW = $clog2(NUM_ENTRIES + 1);
    localparam int KW = VALUE_BITS + IW;
    localparam int AW = VALUE_BITS + IW;

    // Configuration registers
    logic [CFG_BITS-1:0] r_entries;
    logic [CFG_BITS-1:0] r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= CFG_BITS'(64);
            r_top     <= CFG_BITS'(1);
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                REG_ENTRIES_IN_USE: r_entries <= i_cfg_data;
                REG_TOP_COUNT:      r_top     <= i_cfg_data;
                default:            r_entries <= r_entries;
            endcase
        end
    end

    // Effective entry count and top count
    logic [NW-1:0] w_n;
    logic [NW-1:0] w_k;

    always_comb begin
        if (r_entries == '0)
            w_n = NW'(1);
        else if (32'(r_entries) > NUM_ENTRIES)
            w_n = NW'(NUM_ENTRIES);
        else
            w_n = NW'(r_entries);
        if (32'(r_top) > 32'(w_n))
            w_k = w_n;
        else
            w_k = NW'(r_top);
    end

    // Sorted cell chain, largest key first; key is {value, index}
    logic [VALUE_BITS-1:0] r_val [NUM_ENTRIES];
    logic [IW-1:0]         r_idx [NUM_ENTRIES];

    // Item registers
    logic [IW-1:0]         r_e;
    logic [VALUE_BITS-1:0] r_v;
    logic [VALUE_BITS-1:0] r_old;
    logic                  r_err;
    logic [IW-1:0]         r_step;
    logic [AW-1:0]         r_acc;
    logic [NW-1:0]         r_cnt;
    logic [SUM_BITS-1:0]   r_sum;

    logic [KW-1:0] w_key_old;
    logic [KW-1:0] w_key_new;
    logic          w_gt_old [NUM_ENTRIES];
    logic          w_gt_new [NUM_ENTRIES];
    logic          w_take;
    logic [AW-1:0] w_acc_nx;

    assign w_key_old = {r_old, r_e};
    assign w_key_new = {r_v, r_e};

    // Per-cell key compares
    always_comb begin
        for (int j = 0; j < NUM_ENTRIES; j++) begin
            w_gt_old[j] = {r_val[j], r_idx[j]} > w_key_old;
            w_gt_new[j] = (j < NUM_ENTRIES - 1) && ({r_val[j], r_idx[j]} > w_key_new);
        end
    end

    // Rotate, remove, insert
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_ENTRIES; j++) begin
                r_val[j] <= '0;
                r_idx[j] <= IW'(NUM_ENTRIES - 1 - j);
            end
        end else if (i_cmd.find || i_cmd.accum) begin
            for (int j = 0; j < NUM_ENTRIES; j++) begin
                r_val[j] <= r_val[(j + 1) % NUM_ENTRIES];
                r_idx[j] <= r_idx[(j + 1) % NUM_ENTRIES];
            end
        end else if (i_cmd.remove) begin
            for (int j = 0; j < NUM_ENTRIES - 1; j++) begin
                if (!w_gt_old[j]) begin
                    r_val[j] <= r_val[j + 1];
                    r_idx[j] <= r_idx[j + 1];
                end
            end
        end else if (i_cmd.insert) begin
            for (int j = 0; j < NUM_ENTRIES; j++) begin
                if (!w_gt_new[j]) begin
                    if (j == 0 || w_gt_new[(j + NUM_ENTRIES - 1) % NUM_ENTRIES]) begin
                        r_val[j] <= r_v;
                        r_idx[j] <= r_e;
                    end else begin
                        r_val[j] <= r_val[(j + NUM_ENTRIES - 1) % NUM_ENTRIES];
                        r_idx[j] <= r_idx[(j + NUM_ENTRIES - 1) % NUM_ENTRIES];
                    end
                end
            end
        end
    end

    // Step counter for the two rotation passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.load) begin
            r_step <= '0;
        end else if (i_cmd.find || i_cmd.accum) begin
            if (o_status.last)
                r_step <= '0;
            else
                r_step <= r_step + IW'(1);
        end
    end

    assign o_status.last = (r_step == IW'(NUM_ENTRIES - 1));
    assign o_status.err  = r_err;

    // Add the head cell while it is in use and the count is not reached
    assign w_take   = (32'(r_idx[0]) < 32'(w_n)) && (r_cnt < w_k);
    assign w_acc_nx = w_take ? r_acc + AW'(r_val[0]) : r_acc;

    // Latch the word, capture old value, accumulate the top values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_e   <= i_entry_index;
            r_v   <= i_new_value;
            r_err <= 32'(i_entry_index) >= 32'(w_n);
            r_acc <= '0;
            r_cnt <= '0;
        end else if (i_cmd.find) begin
            if (r_idx[0] == r_e)
                r_old <= r_val[0];
        end else if (i_cmd.accum) begin
            if (w_take) begin
                r_acc <= w_acc_nx;
                r_cnt <= r_cnt + NW'(1);
            end
        end
    end

    // Saturate the total, including the last scanned cell, into the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (64'(w_acc_nx) > 64'((64'd1 << SUM_BITS) - 64'd1))
                r_sum <= '1;
            else
                r_sum <= SUM_BITS'(w_acc_nx);
        end
    end

    assign o_top_sum     = r_sum;
    assign o_index_error = r_err;

endmodule
`default_nettype wire

[sv/tkst_ctrl.sv]
`default_nettype none
module tkst_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  wire                 i_ready,
    input  tkst_pkg::t_status   i_status,
    output tkst_pkg::t_cmd      o_cmd
);
    import tkst_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FIND;
                end
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                if (i_status.last)
                    n_state = i_status.err ? S_SCAN : S_REMOVE;
            end
            S_REMOVE: begin
                o_cmd.remove = 1'b1;
                n_state      = S_INSERT;
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.accum = 1'b1;
                if (i_status.last)
                    n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.finish = 1'b0;
                o_valid      = 1'b1;
                if (i_ready)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // Latch the result as the scan ends
        if (r_state == S_SCAN && i_status.last)
            o_cmd.finish = 1'b1;
    end

    a_err_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND && i_status.last && i_status.err) |=> r_state == S_SCAN)
        else $error("bad index did not skip the update");
    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_status.last) |=> r_state == S_DONE)
        else $error("scan did not end in result state");
    a_insert_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INSERT |-> $past(r_state) == S_REMOVE)
        else $error("insert without remove");

endmodule
`default_nettype wire

[sv/top_k_sum_tracker_core.sv]
`default_nettype none
// Top-K sum tracker. Holds NUM_ENTRIES unsigned values (zero after reset) in a chain of
// cells kept sorted by value, largest first. Each input word overwrites one entry and
// returns the sum of the top_count largest values among entries below entries_in_use;
// an index at or beyond entries_in_use leaves the table alone and sets index_error.
// A rotation pass of the chain finds the old value, a remove step takes it out, an insert
// step puts the new one in, and a second rotation pass adds up the top values, one cell
// per cycle. The user must write the configuration registers only while no word is in
// flight; the block itself does not enforce this.
module top_k_sum_tracker_core #(
    parameter int NUM_ENTRIES = tkst_pkg::NUM_ENTRIES_DEF,
    parameter int VALUE_BITS  = tkst_pkg::VALUE_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_wen,
    input  wire                             i_cfg_index,
    input  wire [tkst_pkg::CFG_BITS-1:0]    i_cfg_data,
    input  wire                             i_valid,
    output logic                            o_ready,
    input  wire [$clog2(NUM_ENTRIES)-1:0]   i_entry_index,
    input  wire [VALUE_BITS-1:0]            i_new_value,
    output logic                            o_valid,
    input  wire                             i_ready,
    output logic [tkst_pkg::SUM_BITS-1:0]   o_top_sum,
    output logic                            o_index_error
);
    import tkst_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    tkst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    tkst_datapath #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_entry_index (i_entry_index),
        .i_new_value   (i_new_value),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_top_sum     (o_top_sum),
        .o_index_error (o_index_error)
    );

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import tkst_pkg::*;

    localparam int N_ENT = NUM_ENTRIES_DEF;
    localparam int LATENCY = 2 * N_ENT + 8;

    typedef struct packed {
        logic [SUM_BITS-1:0] top_sum;
        logic                index_error;
    } t_result;

    typedef struct {
        bit              chk;
        logic [5:0]      idx;
        logic [31:0]     val;
        t_result         exp;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wen;
    logic                i_cfg_index;
    logic [CFG_BITS-1:0] i_cfg_data;
    logic                i_valid;
    logic                o_ready;
    logic [5:0]          i_entry_index;
    logic [31:0]         i_new_value;
    logic                o_valid;
    logic                i_ready;
    logic [SUM_BITS-1:0] o_top_sum;
    logic                o_index_error;

    top_k_sum_tracker_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_entry_index(i_entry_index), .i_new_value(i_new_value),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_top_sum(o_top_sum), .o_index_error(o_index_error)
    );

    // Shadow of the table and registers
    logic [31:0]          table_vals [N_ENT];
    logic [CFG_BITS-1:0]  shadow_entries;
    logic [CFG_BITS-1:0]  shadow_top;
    t_result              pending_sums [$];
    int                   error_count;
    int                   send_idle_pct;
    int                   recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int active_entries();
        int n;
        n = shadow_entries;
        if (n == 0) n = 1;
        if (n > N_ENT) n = N_ENT;
        return n;
    endfunction

    // Apply one update to the shadow table and return the top-K sum
    function automatic t_result apply_update(logic [5:0] idx, logic [31:0] val);
        t_result r;
        logic [31:0] ordered [$];
        logic [SUM_BITS+1:0] acc;
        int n;
        int k;
        n = active_entries();
        k = shadow_top;
        if (k > n) k = n;
        r.index_error = (idx >= n);
        if (!r.index_error) table_vals[idx] = val;
        for (int i = 0; i < n; i++) ordered.insert(ordered.size(), table_vals[i]);
        ordered.rsort();
        acc = '0;
        for (int i = 0; i < k; i++) acc += ordered[i];
        if (acc > {SUM_BITS{1'b1}}) acc = {SUM_BITS{1'b1}};
        r.top_sum = acc[SUM_BITS-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Receiver: random stall, compare each word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_sums.size() == 0) begin
                    report_mismatch("unexpected word", o_top_sum, 0);
                end else begin
                    t_result e;
                    e = pending_sums.pop_front();
                    if (o_top_sum !== e.top_sum)
                        report_mismatch("top_sum", o_top_sum, e.top_sum);
                    if (o_index_error !== e.index_error)
                        report_mismatch("index_error", o_index_error, e.index_error);
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Write one register, then leave the port quiet before returning
    task automatic write_reg(logic idx, logic [CFG_BITS-1:0] data);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        if (idx == REG_ENTRIES_IN_USE) shadow_entries = data;
        else shadow_top = data;
        @(posedge i_clk);
    endtask

    // Drive one word, hold until accepted, then queue the expected result
    task automatic send_word(logic [5:0] idx, logic [31:0] val, bit chk, t_result exp);
        t_result p;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_entry_index <= idx;
        i_new_value   <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        p = apply_update(idx, val);
        if (chk && p !== exp) report_mismatch("directed table", p, exp);
        pending_sums.insert(pending_sums.size(), p);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0: return 32'hFFFF_FFFF - $urandom_range(3);
            1: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    t_row directed [$];

    initial begin
        t_row row;
        t_result none;
        logic [6:0] cfg_e;
        logic [6:0] cfg_k;
        none = '0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        shadow_entries = 7'd64;
        shadow_top = 7'd1;
        foreach (table_vals[i]) table_vals[i] = '0;
        i_rst_n = 1'b0;
        i_cfg_wen = 1'b0;
        i_cfg_index = REG_ENTRIES_IN_USE;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_entry_index = '0;
        i_new_value = '0;
        i_ready = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: values at the extremes under reset registers (K=1)
        directed.insert(directed.size(), '{1, 6'd0,  32'd0,         '{38'd0, 1'b0}});
        directed.insert(directed.size(), '{1, 6'd63, 32'hFFFF_FFFF, '{38'hFFFF_FFFF, 1'b0}});
        directed.insert(directed.size(), '{1, 6'd5,  32'd7,         '{38'hFFFF_FFFF, 1'b0}});
        directed.insert(directed.size(), '{1, 6'd63, 32'd3,         '{38'd7, 1'b0}});
        directed.insert(directed.size(), '{0, 6'd10, 32'd7,         none});
        directed.insert(directed.size(), '{0, 6'd42, 32'hAAAA_5555, none});
        foreach (directed[i]) begin
            row = directed[i];
            send_word(row.idx, row.val, row.chk, row.exp);
        end
        drain();

        // Entries in use of zero acts as one; out-of-range index flags
        write_reg(REG_ENTRIES_IN_USE, 7'd0);
        write_reg(REG_TOP_COUNT, 7'd0);
        send_word(6'd1, 32'd9, 1, '{38'd0, 1'b1});
        send_word(6'd0, 32'd4, 1, '{38'd0, 1'b0});
        drain();
        write_reg(REG_TOP_COUNT, 7'd127);
        send_word(6'd0, 32'd6, 1, '{38'd6, 1'b0});
        send_word(6'd63, 32'd1, 1, '{38'd6, 1'b1});
        drain();
        // Saturated entries, all summed; tie values
        write_reg(REG_ENTRIES_IN_USE, 7'd127);
        write_reg(REG_TOP_COUNT, 7'd64);
        for (int i = 0; i < 6; i++) send_word(6'(i * 11), 32'hFFFF_FFFF, 0, none);
        send_word(6'd20, 32'h8000_0000, 0, none);
        drain();
        write_reg(REG_TOP_COUNT, 7'd2);
        send_word(6'd33, 32'hFFFF_FFFF, 1, '{38'h1_FFFF_FFFE, 1'b0});
        drain();

        // Random phases over varied settings and idling
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            case (ph)
                0: begin cfg_e = 7'd64; cfg_k = 7'd64; end
                1: begin cfg_e = 7'd1;  cfg_k = 7'd1;  end
                2: begin cfg_e = 7'd64; cfg_k = 7'd1;  end
                3: begin cfg_e = 7'd2;  cfg_k = 7'd0;  end
                4: begin cfg_e = 7'd127; cfg_k = 7'd127; end
                default: begin
                    cfg_e = $urandom_range(0, 127);
                    cfg_k = $urandom_range(0, 127);
                end
            endcase
            write_reg(REG_ENTRIES_IN_USE, cfg_e);
            write_reg(REG_TOP_COUNT, cfg_k);
            for (int i = 0; i < 120; i++) begin
                logic [5:0] idx;
                idx = ($urandom_range(9) == 0) ? 6'($urandom) :
                      6'($urandom_range(active_entries() - 1));
                send_word(idx, rand_value(), 0, none);
                // Hold off until the block has drained once per phase
                if (i == 60) begin
                    i_valid <= 1'b0;
                    while (pending_sums.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
